// ===== rtl/mles_pkg.sv =====
// Shared types, codes and day helpers for the light event scheduler.
package mles_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 32;
   localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;

   localparam logic [3:0] DAY_EVERY   = 4'd10;
   localparam logic [3:0] DAY_WEEKEND = 4'd11;
   localparam logic [3:0] DAY_WEEKDAY = 4'd12;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [7:0]  light;
      logic [3:0]  day;
      logic [10:0] minute;
      logic        on;
      logic        active;
   } entry_type;

   function automatic logic day_code_ok(input logic [3:0] d);
      return d inside {[4'd1:4'd7], DAY_EVERY, DAY_WEEKEND, DAY_WEEKDAY};
   endfunction

   function automatic logic day_matches(input logic [3:0] code, input logic [3:0] today);
      logic m;
      case (code)
         DAY_EVERY:   m = 1'b1;
         DAY_WEEKEND: m = today inside {4'd6, 4'd7};
         DAY_WEEKDAY: m = today inside {[4'd1:4'd5]};
         default:     m = (code == today);
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/mles_table.sv =====
// Event table storage: one write port, one registered read port.
module mles_table #(
   parameter int unsigned ENTRIES = mles_pkg::ENTRIES_DEFAULT,
   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output mles_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  mles_pkg::entry_type wr_data
);
   import mles_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/minute_light_event_scheduler_unit.sv =====
// Light event scheduler: command sequencer around a single event table memory.
//
//   port group   dir   beat marked by          payload
//   req_*        in    start & !busy           command, lamp, day_code, minute, turn_on
//   rsp_*        out   rsp_strobe (one cycle)  kind, status, count, action_light,
//                                              action_on, last
//
// Add and tick walk the stored entries through the table read port, one entry per
// cycle. Remove walks the same way and then moves each later entry down one place,
// one per cycle. An unused command is answered straight from idle. Reset zeroes the
// entry count, so the table reads as empty. Results cannot be stalled; a tick's
// actions go out as they are found, each held until the next is found so the final
// one can carry last.
module minute_light_event_scheduler_unit #(
   parameter int unsigned ENTRIES = mles_pkg::ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_lamp,
   input  logic [3:0]  req_day_code,
   input  logic [10:0] req_minute,
   input  logic        req_turn_on,
   output logic        rsp_strobe,
   output logic        rsp_kind,
   output logic        rsp_status,
   output logic [5:0]  rsp_count,
   output logic [7:0]  rsp_action_light,
   output logic        rsp_action_on,
   output logic        rsp_last
);
   import mles_pkg::*;

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic        pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic        hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic        hold_v_ff, hold_v_in;
   logic [7:0]  hold_light_ff, hold_light_in;
   logic        hold_on_ff, hold_on_in;

   cmd_type     cmd_ff, cmd_in;
   logic [7:0]  light_ff, light_in;
   logic [3:0]  day_ff, day_in;
   logic [10:0] minute_ff, minute_in;
   logic        turn_on_ff, turn_on_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_count_ff, rsp_count_in;
   logic [7:0]  rsp_light_ff, rsp_light_in;
   logic        rsp_on_ff, rsp_on_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        rd_en;
   logic [AW-1:0] rd_addr;
   entry_type   rd_data;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   entry_type   wr_data;

   logic        more;
   logic        key_hit;
   logic        dm;
   logic        fire_off;
   logic        fire_on;
   logic        add_ok;

   mles_table #(.ENTRIES(ENTRIES)) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign more    = (issue_ff < count_ff);
   assign key_hit = (rd_data.light == light_ff) && (rd_data.day == day_ff) &&
                    (rd_data.minute == minute_ff);
   assign dm       = day_matches(rd_data.day, day_ff);
   assign fire_off = dm && rd_data.active &&
                     (({1'b0, rd_data.minute} + 12'd1) == {1'b0, minute_ff});
   assign fire_on  = dm && (rd_data.minute == minute_ff);
   assign add_ok   = (count_ff < CW'(ENTRIES)) && (minute_ff < MINUTES_PER_DAY) &&
                     day_code_ok(day_ff) && !hit_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hold_v_in     = hold_v_ff;
      hold_light_in = hold_light_ff;
      hold_on_in    = hold_on_ff;
      cmd_in        = cmd_ff;
      light_in      = light_ff;
      day_in        = day_ff;
      minute_in     = minute_ff;
      turn_on_in    = turn_on_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = 1'b0;
      rsp_status_in = 1'b0;
      rsp_light_in  = 8'd0;
      rsp_on_in     = 1'b0;
      rsp_last_in   = 1'b1;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff;
      wr_data       = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = cmd_type'(req_command);
               light_in   = req_lamp;
               day_in     = req_day_code;
               minute_in  = req_minute;
               turn_on_in = req_turn_on;
               case (req_command)
                  CMD_ADD, CMD_REMOVE, CMD_TICK: begin
                     state_in  = ST_SCAN;
                     issue_in  = '0;
                     hit_in    = 1'b0;
                     hold_v_in = 1'b0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (more) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end
            if (pend_ff) begin
               case (cmd_ff)
                  CMD_TICK: begin
                     // entries never revisit within a pass, so write-back can't collide
                     if (fire_off || fire_on) begin
                        wr_en          = 1'b1;
                        wr_data.active = !fire_off;
                        if (hold_v_ff) begin
                           rsp_strobe_in = 1'b1;
                           rsp_kind_in   = 1'b1;
                           rsp_light_in  = hold_light_ff;
                           rsp_on_in     = hold_on_ff;
                           rsp_last_in   = 1'b0;
                        end
                        hold_v_in     = 1'b1;
                        hold_light_in = rd_data.light;
                        hold_on_in    = fire_off ? !rd_data.on : rd_data.on;
                     end
                  end
                  default: begin
                     if (key_hit && !hit_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = pend_idx_ff;
                     end
                  end
               endcase
            end else if (!more) begin
               state_in = ST_IDLE;
               case (cmd_ff)
                  CMD_ADD: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = !add_ok;
                     if (add_ok) begin
                        wr_en          = 1'b1;
                        wr_addr        = count_ff[AW-1:0];
                        wr_data.light  = light_ff;
                        wr_data.day    = day_ff;
                        wr_data.minute = minute_ff;
                        wr_data.on     = turn_on_ff;
                        wr_data.active = 1'b0;
                        count_in       = count_ff + CW'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_ff) begin
                        state_in = ST_SHIFT;
                        issue_in = CW'(hit_idx_ff) + CW'(1);
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = 1'b1;
                     end
                  end
                  default: begin
                     if (hold_v_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_kind_in   = 1'b1;
                        rsp_light_in  = hold_light_ff;
                        rsp_on_in     = hold_on_ff;
                     end
                     hold_v_in = 1'b0;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            if (more) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end
            if (pend_ff) begin
               // move entry down one place into the gap
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - AW'(1);
            end else if (!more) begin
               state_in      = ST_IDLE;
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = 6'(count_in);
   end

   always_ff @(posedge clock) begin
      state_ff      <= state_in;
      count_ff      <= count_in;
      issue_ff      <= issue_in;
      pend_ff       <= pend_in;
      pend_idx_ff   <= pend_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hold_v_ff     <= hold_v_in;
      hold_light_ff <= hold_light_in;
      hold_on_ff    <= hold_on_in;
      cmd_ff        <= cmd_in;
      light_ff      <= light_in;
      day_ff        <= day_in;
      minute_ff     <= minute_in;
      turn_on_ff    <= turn_on_in;
      rsp_strobe_ff <= rsp_strobe_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_light_ff  <= rsp_light_in;
      rsp_on_ff     <= rsp_on_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         hold_v_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_action_light = rsp_light_ff;
   assign rsp_action_on    = rsp_on_ff;
   assign rsp_last         = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count above table size");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("table write beyond stored entries");

   a_reply_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_kind) |-> rsp_last)
      else $error("command reply without last");

   a_action_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind) |-> !rsp_status)
      else $error("light action with reject status");

   a_shift_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (hit_ff && cmd_ff == CMD_REMOVE))
      else $error("compaction without a matching entry");

endmodule
